// ----- hw/rtl/tke_pkg.sv -----
// package for the touch keyboard encoder: item types, key codes and layer tables
package tke_pkg;

    typedef struct packed {
        logic       kind;
        logic [8:0] touch_x;
        logic [7:0] touch_y;
        logic [1:0] arrow;
    } press_t;

    typedef struct packed {
        logic       byte_valid;
        logic [6:0] code;
        logic       last;
        logic [1:0] layer_now;
        logic       ctrl_pending;
    } sym_t;

    // kind codes
    localparam logic KIND_TOUCH = 1'b0;
    localparam logic KIND_ARROW = 1'b1;

    // layer codes
    localparam logic [1:0] LAYER_LOWER = 2'd0;
    localparam logic [1:0] LAYER_SHIFT = 2'd1;
    localparam logic [1:0] LAYER_SYM1  = 2'd2;
    localparam logic [1:0] LAYER_SYM2  = 2'd3;

    // arrow sequence beats
    localparam logic [1:0] BEAT_ESC    = 2'd0;
    localparam logic [1:0] BEAT_CSI    = 2'd1;
    localparam logic [1:0] BEAT_LETTER = 2'd2;

    // keyboard geometry
    localparam logic [7:0] KB_TOP    = 8'd38;
    localparam logic [7:0] ROW_PITCH = 8'd38;
    localparam logic [7:0] KB_BOTTOM = 8'd228;
    localparam logic [3:0] LAST_COL  = 4'd9;
    localparam logic [2:0] SPACE_ROW = 3'd4;
    localparam logic [3:0] SPACE_LO  = 4'd3;
    localparam logic [3:0] SPACE_HI  = 4'd6;

    // key codes: modifier codes 1 to 5, which are not control characters, and character codes
    localparam logic [7:0] MK_SHIFT = 8'd1;
    localparam logic [7:0] MK_SYM   = 8'd2;
    localparam logic [7:0] MK_ABC   = 8'd3;
    localparam logic [7:0] MK_SYM2  = 8'd4;
    localparam logic [7:0] MK_CTRL  = 8'd5;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_ENTER = 8'd10;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CSI   = 8'd91;
    localparam logic [7:0] CH_A_UP  = 8'd65;
    localparam logic [7:0] CH_Z_UP  = 8'd90;
    localparam logic [7:0] CH_A_LO  = 8'd97;
    localparam logic [7:0] CH_Z_LO  = 8'd122;
    localparam logic [7:0] CH_GRAVE = 8'h60;
    localparam logic [6:0] CTRL_UP_OFS = 7'd64;
    localparam logic [6:0] CTRL_LO_OFS = 7'd96;

    localparam logic [7:0] KEY_ROM [0:3][0:4][0:9] = '{
        '{ '{"1","2","3","4","5","6","7","8","9","0"},
           '{"q","w","e","r","t","y","u","i","o","p"},
           '{"a","s","d","f","g","h","j","k","l","'"},
           '{MK_SHIFT,"z","x","c","v","b","n","m",",","."},
           '{CH_TAB,CH_ESC,MK_SYM," "," "," "," ",MK_CTRL,CH_ENTER,CH_DEL} },
        '{ '{"!","@","#","$","%","^","&","*","(",")"},
           '{"Q","W","E","R","T","Y","U","I","O","P"},
           '{"A","S","D","F","G","H","J","K","L","\""},
           '{MK_SHIFT,"Z","X","C","V","B","N","M",";",":"},
           '{CH_TAB,CH_ESC,MK_SYM," "," "," "," ",MK_CTRL,CH_ENTER,CH_DEL} },
        '{ '{"1","2","3","4","5","6","7","8","9","0"},
           '{"+","-","*","/","=","|","\\",CH_GRAVE,"~","_"},
           '{"@","#","$","%","^","&","(",")","[","]"},
           '{MK_SYM2,"{","}","<",">","?","!",":",";","\""},
           '{CH_TAB,CH_ESC,MK_ABC," "," "," "," ",MK_CTRL,CH_ENTER,CH_DEL} },
        '{ '{CH_GRAVE,"~","|","\\","_","-","+","=",".",","},
           '{"[","]","{","}","<",">","(",")","/","?"},
           '{"!","@","#","$","%","^","&","*","'","\""},
           '{MK_ABC,":",";","-","_","+","=","\\","|","~"},
           '{CH_TAB,CH_ESC,MK_ABC," "," "," "," ",MK_CTRL,CH_ENTER,CH_DEL} }
    };

endpackage

// ----- hw/rtl/touch_keyboard_encoder.sv -----
// touch keyboard encoder: touch and arrow presses in, terminal bytes out
//
//   channel   payload   handshake              items
//   press     press_t   press_valid / stall    one touch or arrow press
//   sym       sym_t     sym_valid / sym_stall  one byte or status result
//
// a touch press gives one result, an arrow press gives three (esc, '[', letter)
// an item stays in the input register while it gives its results, one each time
// the result register can take one; the result register is the only other stage,
// and each result is registered into it
// reset clears both registers' valid flags, the beat counter, layer and control
// a stalled result holds; the input register takes a new item while the result
// waits only if it is empty, and keeps its item until its last result moves on
module touch_keyboard_encoder
    import tke_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   press_valid,
    output logic   press_stall,
    input  press_t press,
    output logic   sym_valid,
    input  logic   sym_stall,
    output sym_t   sym
);

    // input register
    logic       in_valid_reg;
    press_t     in_reg;
    // result register
    logic       out_valid_reg;
    sym_t       out_reg;
    // arrow beat counter
    logic [1:0] beat_reg;
    logic [1:0] beat_next;
    // keyboard state
    logic [1:0] layer_reg;
    logic [1:0] layer_next;
    logic       ctrl_reg;
    logic       ctrl_next;

    logic       advance;
    logic       item_done;
    sym_t       res;

    // touch decode
    logic [7:0] y_ofs;
    logic       on_board;
    logic [2:0] row;
    logic [8:0] x_ofs;
    logic [3:0] col_raw;
    logic [3:0] col;
    logic [7:0] key;
    logic [6:0] key7;

    // result register can take a new result
    assign advance   = !out_valid_reg || !sym_stall;
    // the held item gives its final result this cycle
    assign item_done = in_valid_reg && advance &&
                       ((in_reg.kind == KIND_TOUCH) || (beat_reg == BEAT_LETTER));

    assign press_stall = in_valid_reg && !item_done;

    // row from the vertical offset by compare against multiples of the pitch
    always_comb
    begin
        y_ofs    = in_reg.touch_y - KB_TOP;
        on_board = (in_reg.touch_y >= KB_TOP) && (in_reg.touch_y < KB_BOTTOM);
        if (y_ofs >= 8'(4 * ROW_PITCH))
            row = 3'd4;
        else if (y_ofs >= 8'(3 * ROW_PITCH))
            row = 3'd3;
        else if (y_ofs >= 8'(2 * ROW_PITCH))
            row = 3'd2;
        else if (y_ofs >= ROW_PITCH)
            row = 3'd1;
        else
            row = 3'd0;

        // column pitch is 32 pixels, so the divide is a shift
        x_ofs   = (in_reg.touch_x == 9'd0) ? 9'd0 : in_reg.touch_x - 9'd1;
        col_raw = x_ofs[8:5];
        col     = (col_raw > LAST_COL) ? LAST_COL : col_raw;
        // the space bar spans four columns
        if ((row == SPACE_ROW) && (col >= SPACE_LO) && (col <= SPACE_HI))
            col = SPACE_LO;

        key  = KEY_ROM[layer_reg][row][col];
        key7 = key[6:0];
    end

    // result and state update for the held item
    always_comb
    begin
        layer_next = layer_reg;
        ctrl_next  = ctrl_reg;
        beat_next  = beat_reg;
        res        = '0;
        res.last   = 1'b1;

        if (in_reg.kind == KIND_ARROW)
        begin
            res.byte_valid = 1'b1;
            case (beat_reg)
                BEAT_ESC:
                begin
                    res.code  = CH_ESC[6:0];
                    res.last  = 1'b0;
                    beat_next = BEAT_CSI;
                end
                BEAT_CSI:
                begin
                    res.code  = CH_CSI[6:0];
                    res.last  = 1'b0;
                    beat_next = BEAT_LETTER;
                end
                default:
                begin
                    res.code  = CH_A_UP[6:0] + {5'd0, in_reg.arrow};
                    beat_next = BEAT_ESC;
                end
            endcase
        end
        else if (on_board)
        begin
            case (key)
                MK_SHIFT: layer_next = (layer_reg == LAYER_SHIFT) ? LAYER_LOWER : LAYER_SHIFT;
                MK_SYM:   layer_next = LAYER_SYM1;
                MK_ABC:   layer_next = LAYER_LOWER;
                MK_SYM2:  layer_next = LAYER_SYM2;
                MK_CTRL:  ctrl_next  = !ctrl_reg;
                CH_TAB, CH_ESC, CH_ENTER, CH_DEL, CH_SPACE:
                begin
                    res.byte_valid = 1'b1;
                    res.code       = key7;
                end
                default:
                begin
                    res.byte_valid = 1'b1;
                    if (ctrl_reg)
                    begin
                        ctrl_next = 1'b0;
                        if ((key >= CH_A_LO) && (key <= CH_Z_LO))
                            res.code = key7 - CTRL_LO_OFS;
                        else if ((key >= CH_A_UP) && (key <= CH_Z_UP))
                            res.code = key7 - CTRL_UP_OFS;
                        else
                            res.code = key7;
                    end
                    else
                    begin
                        res.code = key7;
                        if (layer_reg == LAYER_SHIFT)
                            layer_next = LAYER_LOWER;
                    end
                end
            endcase
        end

        // status fields show the state after this item
        res.layer_now    = layer_next;
        res.ctrl_pending = ctrl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_ESC;
            layer_reg     <= LAYER_LOWER;
            ctrl_reg      <= 1'b0;
        end
        else
        begin
            if (press_valid && !press_stall)
                in_valid_reg <= 1'b1;
            else if (item_done)
                in_valid_reg <= 1'b0;

            if (in_valid_reg && advance)
            begin
                out_valid_reg <= 1'b1;
                beat_reg      <= beat_next;
                layer_reg     <= layer_next;
                ctrl_reg      <= ctrl_next;
            end
            else if (advance)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (press_valid && !press_stall)
            in_reg <= press;
        if (in_valid_reg && advance)
            out_reg <= res;
    end

    assign sym_valid = out_valid_reg;
    assign sym       = out_reg;

    // only arrow sequences give results that are not the last of their item
    a_not_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> out_reg.byte_valid)
        else $error("non-final result without a byte");

    // the beat counter only moves while an arrow item is held
    a_beat_arrow: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg != BEAT_ESC |-> in_valid_reg && (in_reg.kind == KIND_ARROW))
        else $error("arrow beat without an arrow item");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg != 2'd3)
        else $error("arrow beat out of range");

    // arrow presses leave layer and control untouched
    a_arrow_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (in_reg.kind == KIND_ARROW) |=>
            (layer_reg == $past(layer_reg)) && (ctrl_reg == $past(ctrl_reg)))
        else $error("arrow press changed keyboard state");

endmodule
